/* design/mlfu_pkg.sv */
`timescale 1ns / 1ps

package mlfu_pkg;

   // defaults for the top level parameters
   localparam int SITES_DEF          = 16384;
   localparam int MAX_NEIGHBOURS_DEF = 4;
   localparam int TABLE_DEPTH_DEF    = 256;

   // fixed field widths
   localparam int SITE_W   = 14;
   localparam int DEGREE_W = 3;
   localparam int WEIGHT_W = 8;
   localparam int LABEL_W  = 3;
   localparam int TIDX_W   = 8;
   localparam int PROB_W   = 16;
   localparam int GAIN_W   = 16;
   localparam int LCNT_W   = 4;
   localparam int ENERGY_W = 16;

   // input fields carried on the request tdata bus
   localparam int INPUT_NEIGHBOURS = 4;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 24;

   localparam logic [GAIN_W-1:0] GAIN_RESET        = 16'd3932;
   localparam logic [LCNT_W-1:0] LABEL_COUNT_RESET = 4'd7;

   typedef enum logic [1:0] {
      KIND_LOAD_SITE  = 2'd0,
      KIND_LOAD_TABLE = 2'd1,
      KIND_UPDATE     = 2'd2,
      KIND_READ       = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_WEIGHT_GAIN = 2'd0,
      CSR_LABEL_COUNT = 2'd1,
      CSR_SPARE_2     = 2'd2,
      CSR_SPARE_3     = 2'd3
   } csr_index_type;

endpackage

/* design/metropolis_label_field_update_top.sv */
`timescale 1ns / 1ps
// Sequence: loads pass ST_LOAD, reads ST_READ and skipped updates ST_REC before ST_DONE puts
// the result in the output register; an evaluated update walks its neighbours in ST_NB, one
// neighbour per cycle on the single read port of the label memory, then passes ST_FLD, ST_DEC
// and ST_ACC. A new item is taken only after ST_DONE has handed the result to the output
// register, and ST_DONE waits while a full output register drains.
// Reset (synchronous, active high) clears the sequencer, output valid, gain, label count and
// pending flag; memories hold no reset, the user must write them before reading (not enforced).
module metropolis_label_field_update_top #(
   parameter int SITES          = mlfu_pkg::SITES_DEF,
   parameter int MAX_NEIGHBOURS = mlfu_pkg::MAX_NEIGHBOURS_DEF,
   parameter int TABLE_DEPTH    = mlfu_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = site[13:0], degree[16:14], neighbour_a[30:17], neighbour_b[44:31],
   // neighbour_c[58:45], neighbour_d[72:59], site_weight[80:73], label[83:81],
   // table_index[91:84], table_value[107:92], random_value[123:108], zero[127:124]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mlfu_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [1:0]                        req_tuser,   // kind[1:0]
   // response: tdata = site_label[2:0], accepted[3], skipped[4], energy_change[20:5],
   // zero[23:21]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mlfu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [15:0]                       csr_data
);

   localparam int SW   = (SITES > 2) ? $clog2(SITES) : 1;
   localparam int TW   = $clog2(TABLE_DEPTH);
   localparam int DW   = $clog2(MAX_NEIGHBOURS + 1);
   localparam int KW   = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
   localparam int NW   = mlfu_pkg::SITE_W;
   localparam int RW   = DW + NW * MAX_NEIGHBOURS + mlfu_pkg::WEIGHT_W;
   localparam int SMW  = $clog2(49 * MAX_NEIGHBOURS + 1) + 2;
   localparam int FW   = 19;
   localparam int DLW  = FW + 3;
   localparam int XW   = 17;
   localparam int LW   = mlfu_pkg::LABEL_W;
   localparam int DEGREE_SAT_W = 4;

   localparam logic [XW-1:0]         SITES_X = XW'(SITES);
   localparam logic [15:0]           TDEP_X  = 16'(TABLE_DEPTH);
   localparam logic signed [DLW-1:0] TDEP_S  = DLW'(TABLE_DEPTH);
   localparam logic signed [DLW-1:0] E_MAX   = DLW'(32767);
   localparam logic signed [DLW-1:0] E_MIN   = -DLW'(32768);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_LOAD = 9'b000000010,
      ST_READ = 9'b000000100,
      ST_REC  = 9'b000001000,
      ST_NB   = 9'b000010000,
      ST_FLD  = 9'b000100000,
      ST_DEC  = 9'b001000000,
      ST_ACC  = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   // memories
   logic [RW-1:0]                   rec_mem [SITES];
   logic [LW-1:0]                   lab_mem [SITES];
   logic [mlfu_pkg::PROB_W-1:0]     tbl_mem [TABLE_DEPTH];

   state_type                       state_ff, state_in;
   logic [mlfu_pkg::GAIN_W-1:0]     gain_ff, gain_in;
   logic [mlfu_pkg::LCNT_W-1:0]     lcnt_ff, lcnt_in;

   // latched item
   mlfu_pkg::kind_type              kind_ff;
   logic [SW-1:0]                   site_ff;
   logic                            site_ok_ff;
   logic [DW-1:0]                   ldeg_ff;
   logic [mlfu_pkg::INPUT_NEIGHBOURS-1:0][NW-1:0] lnbr_ff;
   logic [mlfu_pkg::WEIGHT_W-1:0]   lwgt_ff;
   logic [LW-1:0]                   lab_ff;
   logic [TW-1:0]                   tidx_ff;
   logic                            tidx_ok_ff;
   logic [mlfu_pkg::PROB_W-1:0]     tval_ff;
   logic [mlfu_pkg::PROB_W-1:0]     rnd_ff;

   // record of the site under update
   logic [DW-1:0]                   rdeg_ff, rdeg_in;
   logic [MAX_NEIGHBOURS-1:0][NW-1:0] rnbr_ff, rnbr_in;
   logic [LW-1:0]                   cur_ff, cur_in;
   logic [15:0]                     wsq_ff, wsq_in;
   logic [31:0]                     g_ff, g_in;
   logic [DW-1:0]                   cnt_ff, cnt_in;
   logic                            pend_ff, pend_in;
   logic                            pend_ok_ff, pend_ok_in;
   logic signed [SMW-1:0]           sum_ff, sum_in;
   logic [FW-1:0]                   fn_ff, fn_in, fc_ff, fc_in;
   logic signed [DLW-1:0]           delta_ff, delta_in;

   // memory ports
   logic [RW-1:0]                   rec_rd_ff;
   logic [LW-1:0]                   lab_rd_ff;
   logic [mlfu_pkg::PROB_W-1:0]     tbl_rd_ff;
   logic [SW-1:0]                   rec_raddr, lab_raddr;
   logic [TW-1:0]                   tbl_raddr;
   logic                            rec_we, lab_we, tbl_we;
   logic [RW-1:0]                   rec_wdata;
   logic [LW-1:0]                   lab_wdata;

   // result and output registers
   logic [LW-1:0]                   res_label_ff, res_label_in;
   logic                            res_acc_ff, res_acc_in;
   logic                            res_skip_ff, res_skip_in;
   logic [mlfu_pkg::ENERGY_W-1:0]   res_energy_ff, res_energy_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mlfu_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                            req_acc;
   logic [XW-1:0]                   req_site_x;
   logic [15:0]                     req_tidx_x;
   logic [DEGREE_SAT_W-1:0]         req_deg_sat;

   // neighbour walk and arithmetic temporaries
   logic [NW-1:0]                   nb_idx;
   logic [XW-1:0]                   nb_x;
   logic [LW-1:0]                   nb_lab;
   logic signed [LW:0]              dn, dc;
   logic signed [2*LW+1:0]          sq_n, sq_c;
   logic [34:0]                     prod_n, prod_c;
   logic signed [DLW-1:0]           delta_c;
   logic                            pass;
   logic [mlfu_pkg::WEIGHT_W-1:0]   rec_wgt;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_site_x = {3'b000, req_tdata[13:0]};
   assign req_tidx_x = {8'h00, req_tdata[91:84]};
   assign req_deg_sat = ({1'b0, req_tdata[16:14]} > DEGREE_SAT_W'(MAX_NEIGHBOURS))
                        ? DEGREE_SAT_W'(MAX_NEIGHBOURS) : {1'b0, req_tdata[16:14]};

   assign rec_wgt = rec_rd_ff[DW + NW*MAX_NEIGHBOURS +: mlfu_pkg::WEIGHT_W];

   // memory write side and record packing
   always_comb begin
      rec_wdata = '0;
      rec_wdata[DW-1:0] = ldeg_ff;
      for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
         rec_wdata[DW + NW*k +: NW] = (k < mlfu_pkg::INPUT_NEIGHBOURS)
                                      ? lnbr_ff[k % mlfu_pkg::INPUT_NEIGHBOURS] : '0;
      end
      rec_wdata[DW + NW*MAX_NEIGHBOURS +: mlfu_pkg::WEIGHT_W] = lwgt_ff;
   end

   // neighbour address for the walk
   always_comb begin
      nb_idx = rnbr_ff[cnt_ff[KW-1:0]];
      nb_x   = {3'b000, nb_idx};
      nb_lab = pend_ok_ff ? lab_rd_ff : '0;
      dn     = $signed({1'b0, lab_ff}) - $signed({1'b0, nb_lab});
      dc     = $signed({1'b0, cur_ff}) - $signed({1'b0, nb_lab});
      sq_n   = (2*LW+2)'(dn) * (2*LW+2)'(dn);
      sq_c   = (2*LW+2)'(dc) * (2*LW+2)'(dc);
      prod_n = 35'(g_ff) * 35'(lab_ff);
      prod_c = 35'(g_ff) * 35'(cur_ff);
      delta_c = DLW'(sum_ff) + $signed({3'b000, fn_ff}) - $signed({3'b000, fc_ff});
      pass   = (delta_ff <= 0) || ((delta_ff < TDEP_S) && (rnd_ff < tbl_rd_ff));
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      gain_in       = gain_ff;
      lcnt_in       = lcnt_ff;
      rdeg_in       = rdeg_ff;
      rnbr_in       = rnbr_ff;
      cur_in        = cur_ff;
      wsq_in        = wsq_ff;
      g_in          = g_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_ok_in    = 1'b0;
      sum_in        = sum_ff;
      fn_in         = fn_ff;
      fc_in         = fc_ff;
      delta_in      = delta_ff;
      res_label_in  = res_label_ff;
      res_acc_in    = res_acc_ff;
      res_skip_in   = res_skip_ff;
      res_energy_in = res_energy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rec_raddr     = req_site_x[SW-1:0];
      lab_raddr     = req_site_x[SW-1:0];
      tbl_raddr     = delta_c[TW-1:0];
      rec_we        = 1'b0;
      lab_we        = 1'b0;
      tbl_we        = 1'b0;
      lab_wdata     = lab_ff;

      if (csr_valid && csr_ready) begin
         case (mlfu_pkg::csr_index_type'(csr_index))
            mlfu_pkg::CSR_WEIGHT_GAIN: gain_in = csr_data;
            mlfu_pkg::CSR_LABEL_COUNT: lcnt_in = csr_data[mlfu_pkg::LCNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (mlfu_pkg::kind_type'(req_tuser))
                  mlfu_pkg::KIND_UPDATE: state_in = ST_REC;
                  mlfu_pkg::KIND_READ:   state_in = ST_READ;
                  default:               state_in = ST_LOAD;
               endcase
            end
         end
         ST_LOAD: begin
            res_acc_in    = 1'b0;
            res_skip_in   = 1'b0;
            res_energy_in = '0;
            res_label_in  = '0;
            if (kind_ff == mlfu_pkg::KIND_LOAD_SITE) begin
               if (site_ok_ff) begin
                  rec_we       = 1'b1;
                  lab_we       = 1'b1;
                  res_label_in = lab_ff;
               end
            end else begin
               tbl_we = tidx_ok_ff;
            end
            state_in = ST_DONE;
         end
         ST_READ: begin
            res_acc_in    = 1'b0;
            res_skip_in   = 1'b0;
            res_energy_in = '0;
            res_label_in  = site_ok_ff ? lab_rd_ff : '0;
            state_in      = ST_DONE;
         end
         ST_REC: begin
            rdeg_in = rec_rd_ff[DW-1:0];
            for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
               rnbr_in[k] = rec_rd_ff[DW + NW*k +: NW];
            end
            cur_in  = lab_rd_ff;
            wsq_in  = 16'(rec_wgt) * 16'(rec_wgt);
            cnt_in  = '0;
            sum_in  = '0;
            res_acc_in    = 1'b0;
            res_energy_in = '0;
            if (!site_ok_ff) begin
               res_skip_in  = 1'b1;
               res_label_in = '0;
               state_in     = ST_DONE;
            end else if ((rec_wgt == '0) || ({1'b0, lab_ff} >= lcnt_ff)
                         || (lab_ff == lab_rd_ff)) begin
               res_skip_in  = 1'b1;
               res_label_in = lab_rd_ff;
               state_in     = ST_DONE;
            end else begin
               res_skip_in = 1'b0;
               state_in    = ST_NB;
            end
         end
         ST_NB: begin
            g_in = 32'(gain_ff) * 32'(wsq_ff);
            // fold in the label that came back from last cycle's read
            if (pend_ff) begin
               sum_in = sum_ff + SMW'(sq_n) - SMW'(sq_c);
            end
            if (cnt_ff < rdeg_ff) begin
               lab_raddr  = nb_x[SW-1:0];
               pend_in    = 1'b1;
               pend_ok_in = (nb_x < SITES_X);
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               state_in = ST_FLD;
            end
         end
         ST_FLD: begin
            fn_in    = prod_n[34:16];
            fc_in    = prod_c[34:16];
            state_in = ST_DEC;
         end
         ST_DEC: begin
            delta_in = delta_c;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            res_acc_in   = pass;
            res_label_in = pass ? lab_ff : cur_ff;
            lab_we       = pass;
            if (delta_ff > E_MAX) begin
               res_energy_in = 16'h7fff;
            end else if (delta_ff < E_MIN) begin
               res_energy_in = 16'h8000;
            end else begin
               res_energy_in = delta_ff[15:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_energy_ff, res_skip_ff, res_acc_ff, res_label_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= mlfu_pkg::GAIN_RESET;
         lcnt_ff      <= mlfu_pkg::LABEL_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         lcnt_ff      <= lcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff    <= mlfu_pkg::kind_type'(req_tuser);
         site_ff    <= req_site_x[SW-1:0];
         site_ok_ff <= (req_site_x < SITES_X);
         ldeg_ff    <= req_deg_sat[DW-1:0];
         lnbr_ff[0] <= req_tdata[30:17];
         lnbr_ff[1] <= req_tdata[44:31];
         lnbr_ff[2] <= req_tdata[58:45];
         lnbr_ff[3] <= req_tdata[72:59];
         lwgt_ff    <= req_tdata[80:73];
         lab_ff     <= req_tdata[83:81];
         tidx_ff    <= req_tidx_x[TW-1:0];
         tidx_ok_ff <= (req_tidx_x < TDEP_X);
         tval_ff    <= req_tdata[107:92];
         rnd_ff     <= req_tdata[123:108];
      end
      rdeg_ff       <= rdeg_in;
      rnbr_ff       <= rnbr_in;
      cur_ff        <= cur_in;
      wsq_ff        <= wsq_in;
      g_ff          <= g_in;
      cnt_ff        <= cnt_in;
      pend_ok_ff    <= pend_ok_in;
      sum_ff        <= sum_in;
      fn_ff         <= fn_in;
      fc_ff         <= fc_in;
      delta_ff      <= delta_in;
      res_label_ff  <= res_label_in;
      res_acc_ff    <= res_acc_in;
      res_skip_ff   <= res_skip_in;
      res_energy_ff <= res_energy_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // site record memory
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[site_ff] <= rec_wdata;
      end
      rec_rd_ff <= rec_mem[rec_raddr];
   end

   // label memory
   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[site_ff] <= lab_wdata;
      end
      lab_rd_ff <= lab_mem[lab_raddr];
   end

   // acceptance table
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tidx_ff] <= tval_ff;
      end
      tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   // assertions
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request taken while an item is in flight");

   a_acc_skip: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && rsp_tdata[4]))
      else $error("result both accepted and skipped");

   a_skip_energy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[4]) |-> (rsp_tdata[20:5] == '0))
      else $error("skipped update carries an energy change");

   a_lab_write: assert property (@(posedge clock) disable iff (reset)
      lab_we |-> (state_ff == ST_LOAD || state_ff == ST_ACC))
      else $error("label write outside load or write-back");

endmodule
